// ----- rtl/mqd_pkg.sv -----
`timescale 1ns / 1ps
// Package for the quad mip downsampler: payload structs, filter mode codes,
// inter-stage record and the constant tables built at elaboration.
// No dependencies.
package mqd_pkg;

  typedef enum logic [1:0] {
    MODE_DATA   = 2'd0,
    MODE_SRGB   = 2'd1,
    MODE_NORMAL = 2'd2,
    MODE_HDR    = 2'd3
  } mode_e;

  typedef struct packed {
    logic [31:0] tap_bottom_right;
    logic [31:0] tap_bottom_left;
    logic [31:0] tap_top_right;
    logic [31:0] tap_top_left;
  } quad_t;

  typedef struct packed {
    logic       rejected;
    logic [7:0] out_alpha;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
  } texel_t;

  // Record carried through the search steps.
  typedef struct packed {
    mode_e            mode;
    logic [2:0][32:0] s;    // colour sums scaled to Q30
    logic [2:0][35:0] pp;   // (255*a)^2 for the normal test
    logic [2:0]       neg;  // normal component is negative
    logic [21:0]      d;    // squared length of the summed normal
    logic [2:0][7:0]  m;    // result bytes built one bit per step
    logic [3:0][7:0]  avg;  // plain byte averages
  } srch_t;

  localparam int unsigned SearchSteps = 8;

  typedef logic [255:0][31:0] dec_tab_t;
  typedef logic [254:0][30:0] thr_tab_t;
  typedef logic [255:0][16:0] tsq_tab_t;

  localparam logic [63:0] Q30One = 64'd1 << 30;

  function automatic logic [63:0] pow5_q30(input logic [63:0] r);
    logic [63:0] t;
    t = (r * r) >> 30;
    t = (t * t) >> 30;
    return (t * r) >> 30;
  endfunction

  // sRGB decode of n/510 at Q30, evaluated exactly in integers.
  function automatic logic [63:0] lin_q30(input logic [63:0] n);
    logic [63:0] c;
    logic [63:0] c2;
    logic [63:0] r;
    logic [63:0] cand;
    r = '0;
    if (n * 64'd100000 <= 64'd2062950) begin
      return (n * 64'd100 * Q30One + 64'd329460) / 64'd658920;
    end
    c = (((64'd1000 * n + 64'd28050) << 30) + 64'd269025) / 64'd538050;
    if (c > Q30One) begin
      c = Q30One;
    end
    c2 = (c * c) >> 30;
    for (int b = 30; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (cand <= Q30One) begin
        if (pow5_q30(cand) <= c2) begin
          r = cand;
        end
      end
    end
    return (c2 * r) >> 30;
  endfunction

  function automatic dec_tab_t build_dec(input int frac);
    dec_tab_t    tab;
    logic [63:0] v;
    int          sh;
    sh = 30 - frac;
    for (int k = 0; k < 256; k++) begin
      v = (lin_q30(64'(2 * k)) + (64'd1 << (sh - 1))) >> sh;
      tab[k] = v[31:0];
    end
    return tab;
  endfunction

  function automatic thr_tab_t build_thr();
    thr_tab_t    tab;
    logic [63:0] v;
    for (int k = 0; k < 255; k++) begin
      v = lin_q30(64'(2 * k + 1));
      tab[k] = v[30:0];
    end
    return tab;
  endfunction

  // (2m - 256)^2 for each candidate byte m.
  function automatic tsq_tab_t build_tsq();
    tsq_tab_t tab;
    int       t;
    for (int k = 0; k < 256; k++) begin
      t = 2 * k - 256;
      tab[k] = 17'(t * t);
    end
    return tab;
  endfunction

endpackage

// ----- rtl/mqd_front.sv -----
`timescale 1ns / 1ps
// Front end of the downsampler: three stages of decode and sum, normal
// component squares, and length/product. Depends on mqd_pkg.
module mqd_front
  import mqd_pkg::*;
#(
  parameter int LINEAR_FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [2:0] en_i,
  input  logic       in_valid_i,
  input  quad_t      in_data_i,
  input  mode_e      mode_i,
  output logic [2:0] vld_o,
  output srch_t      data_o
);

  localparam int DecW  = LINEAR_FRAC_BITS + 1;
  localparam int SumW  = LINEAR_FRAC_BITS + 3;
  localparam int Shift = 30 - LINEAR_FRAC_BITS;
  localparam dec_tab_t DecTab = build_dec(LINEAR_FRAC_BITS);

  logic [2:0] vld_q;

  // Stage one: table decode and byte sums.
  mode_e            mode1_q;
  logic [2:0][32:0] csum1_d, csum1_q;
  logic [3:0][9:0]  bsum1_d, bsum1_q;
  logic [3:0][31:0] taps;

  // Stage two: signed normal components and their squares.
  mode_e            mode2_q;
  logic [2:0][32:0] csum2_q;
  logic [3:0][7:0]  avg2_d, avg2_q;
  logic [2:0]       neg2_d, neg2_q;
  logic [2:0][19:0] asq2_d, asq2_q;

  // Stage three: squared length and scaled squares.
  srch_t out3_d, out3_q;

  assign taps = {in_data_i.tap_bottom_right, in_data_i.tap_bottom_left,
                 in_data_i.tap_top_right, in_data_i.tap_top_left};

  always_comb begin
    logic [SumW-1:0] acc;
    logic [9:0]      bacc;
    logic [DecW-1:0] ent;
    for (int c = 0; c < 4; c++) begin
      acc  = '0;
      bacc = '0;
      for (int t = 0; t < 4; t++) begin
        ent  = DecW'(DecTab[taps[t][8*c +: 8]]);
        acc  = acc + SumW'(ent);
        bacc = bacc + 10'(taps[t][8*c +: 8]);
      end
      if (c < 3) begin
        csum1_d[c] = 33'(acc) << Shift;
      end
      bsum1_d[c] = bacc;
    end
  end

  always_comb begin
    logic signed [11:0] a;
    logic [10:0]        mag;
    for (int c = 0; c < 4; c++) begin
      avg2_d[c] = 8'((bsum1_q[c] + 10'd2) >> 2);
    end
    for (int c = 0; c < 3; c++) begin
      a         = $signed({1'b0, bsum1_q[c], 1'b0}) - 12'sd1020;
      neg2_d[c] = a[11];
      mag       = a[11] ? 11'(-a) : 11'(a);
      asq2_d[c] = 20'(mag * mag);
    end
  end

  always_comb begin
    out3_d      = '0;
    out3_d.mode = mode2_q;
    out3_d.s    = csum2_q;
    out3_d.neg  = neg2_q;
    out3_d.avg  = avg2_q;
    out3_d.d    = 22'(asq2_q[0]) + 22'(asq2_q[1]) + 22'(asq2_q[2]);
    for (int c = 0; c < 3; c++) begin
      out3_d.pp[c] = 36'(asq2_q[c]) * 36'd65025;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en_i[0]) vld_q[0] <= in_valid_i;
      if (en_i[1]) vld_q[1] <= vld_q[0];
      if (en_i[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mode1_q <= mode_i;
      csum1_q <= csum1_d;
      bsum1_q <= bsum1_d;
    end
    if (en_i[1]) begin
      mode2_q <= mode1_q;
      csum2_q <= csum1_q;
      avg2_q  <= avg2_d;
      neg2_q  <= neg2_d;
      asq2_q  <= asq2_d;
    end
    if (en_i[2]) begin
      out3_q <= out3_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = out3_q;

endmodule

// ----- rtl/mqd_search.sv -----
`timescale 1ns / 1ps
// One step of the bitwise result search for all three channels: decides one
// output bit against the sRGB threshold or the normal test. Depends on mqd_pkg.
module mqd_search
  import mqd_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  srch_t data_i,
  output logic  vld_o,
  output srch_t data_o
);

  localparam logic [7:0] Bit = 8'(128 >> STEP);
  localparam thr_tab_t ThrTab = build_thr();
  localparam tsq_tab_t TsqTab = build_tsq();

  logic  vld_q;
  srch_t data_d, data_q;

  always_comb begin
    logic [7:0]  cand;
    logic [7:0]  idx;
    logic [37:0] prod;
    logic [37:0] pp;
    logic        col_ok;
    logic        nrm_ok;
    data_d = data_i;
    for (int c = 0; c < 3; c++) begin
      cand   = data_i.m[c] | Bit;
      idx    = cand - 8'd1;
      col_ok = data_i.s[c] >= {2'b00, ThrTab[idx]} << 2;
      prod   = 38'(TsqTab[cand]) * 38'(data_i.d);
      pp     = 38'(data_i.pp[c]);
      if (!data_i.neg[c]) begin
        nrm_ok = (cand <= 8'd128) || (pp >= prod);
      end else begin
        nrm_ok = (cand < 8'd128) && (pp <= prod);
      end
      if ((data_i.mode == MODE_SRGB) ? col_ok : nrm_ok) begin
        data_d.m[c] = cand;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ----- rtl/mip_quad_downsample.sv -----
`timescale 1ns / 1ps
// Top level of the 2x2 box mip downsampler with sRGB, normal and data modes and an HDR mode that rejects.
// Depends on mqd_pkg, mqd_front and mqd_search.
//
// Usage: each input transfer on the in_ channel carries one quad of four
// RGBA8 texels; each output transfer on the out_ channel carries the filtered
// texel and the rejected flag. Both channels use valid and stall: a transfer
// happens at a rising edge where valid is high and stall is low.
// The filter mode is written through the cfg_ channel (valid/ready, always
// ready); it must only be changed while the block holds no items.
// Each quad passes from the input transfer to its output transfer through
// three front stages (sRGB table decode and sums, normal squares, normal
// length), eight search stages that each settle one bit of every output
// byte, and the output register. Throughput is one quad per cycle while the
// receiver does not stall; every stage holds a valid bit and loads whenever
// it is empty or its successor loads, so bubbles are squeezed out while the
// receiver stalls and a stall loses nothing.
// Reset empties the pipeline and sets the filter mode to linear data.
module mip_quad_downsample
  import mqd_pkg::*;
#(
  parameter int LINEAR_FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  quad_t      in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output texel_t     out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  localparam int NumStg = 3 + SearchSteps + 1;

  mode_e mode_q;

  logic [NumStg-1:0] vld;
  logic [NumStg-1:0] en;

  srch_t  sd [SearchSteps+1];
  logic   sv [SearchSteps+1];

  logic   out_valid_q;
  texel_t out_data_d, out_data_q;

  // Filter mode register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DATA;
    end else if (cfg_valid_i) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  // Load enables: a stage moves when it is empty or the next stage moves.
  always_comb begin
    en[NumStg-1] = !vld[NumStg-1] || !out_stall_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  mqd_front #(
    .LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en[2:0]),
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .mode_i    (mode_q),
    .vld_o     (vld[2:0]),
    .data_o    (sd[0])
  );

  assign sv[0] = vld[2];

  for (genvar g = 0; g < SearchSteps; g++) begin : g_search
    mqd_search #(
      .STEP(g)
    ) u_search (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en[3+g]),
      .vld_i (sv[g]),
      .data_i(sd[g]),
      .vld_o (sv[g+1]),
      .data_o(sd[g+1])
    );
    assign vld[3+g] = sv[g+1];
  end

  // Final formatting by mode.
  always_comb begin
    srch_t f;
    f          = sd[SearchSteps];
    out_data_d = '0;
    unique case (f.mode)
      MODE_HDR: begin
        out_data_d.rejected = 1'b1;
      end
      MODE_SRGB: begin
        out_data_d.out_red   = f.m[0];
        out_data_d.out_green = f.m[1];
        out_data_d.out_blue  = f.m[2];
        out_data_d.out_alpha = f.avg[3];
      end
      MODE_NORMAL: begin
        if (f.d == '0) begin
          // Degenerate normal: point straight up the Z axis.
          out_data_d.out_red   = 8'd128;
          out_data_d.out_green = 8'd128;
          out_data_d.out_blue  = 8'd255;
        end else begin
          out_data_d.out_red   = f.m[0];
          out_data_d.out_green = f.m[1];
          out_data_d.out_blue  = f.m[2];
        end
        out_data_d.out_alpha = 8'd255;
      end
      default: begin
        out_data_d.out_red   = f.avg[0];
        out_data_d.out_green = f.avg[1];
        out_data_d.out_blue  = f.avg[2];
        out_data_d.out_alpha = f.avg[3];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en[NumStg-1]) begin
      out_valid_q <= sv[SearchSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NumStg-1]) begin
      out_data_q <= out_data_d;
    end
  end

  assign vld[NumStg-1] = out_valid_q;
  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_data_q;

  // A rejected texel always carries zero colour and alpha.
  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rejected |->
      out_data_o.out_red == 8'd0 && out_data_o.out_green == 8'd0 &&
      out_data_o.out_blue == 8'd0 && out_data_o.out_alpha == 8'd0)
    else $error("rejected texel with non-zero payload");

  // An item in the last search stage that cannot move is still there next cycle.
  a_search_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv[SearchSteps] && !en[NumStg-1] |=> sv[SearchSteps])
    else $error("item lost in the last search stage");

  // A full last search stage behind a full, blocked output must not load.
  a_stall_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && vld[NumStg-2] |-> !en[NumStg-2])
    else $error("search stage loads while the output is blocked");

endmodule

// ----- tb/mip_quad_downsample_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for mip_quad_downsample: drives quads in data, sRGB,
// normal and HDR modes and checks every filtered texel against its own model.
// Depends on mqd_pkg and mip_quad_downsample.
module mip_quad_downsample_test;
  import mqd_pkg::*;

  // Predicts filtered texels and holds them until the block returns them.
  class texel_scoreboard;
    texel_t      pending[$];
    int          errors;
    logic [31:0] srgb_lin[256];
    logic [63:0] srgb_mid[255];

    function logic [63:0] fifth_power(input logic [63:0] r);
      logic [63:0] t;
      t = (r * r) >> 30;
      t = (t * t) >> 30;
      return (t * r) >> 30;
    endfunction

    // Linear value of sRGB code n/510 in Q30.
    function logic [63:0] to_linear(input logic [63:0] n);
      logic [63:0] c;
      logic [63:0] c2;
      logic [63:0] root;
      logic [63:0] trial;
      root = 0;
      if (n * 100000 <= 2062950) return (n * 100 * (64'd1 << 30) + 329460) / 658920;
      c = (((1000 * n + 28050) << 30) + 269025) / 538050;
      if (c > (64'd1 << 30)) c = 64'd1 << 30;
      c2 = (c * c) >> 30;
      for (int b = 30; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial <= (64'd1 << 30) && fifth_power(trial) <= c2) root = trial;
      end
      return (c2 * root) >> 30;
    endfunction

    function new();
      for (int k = 0; k < 256; k++) begin
        srgb_lin[k] = 32'((to_linear(2 * k) + (64'd1 << 13)) >> 14);
      end
      for (int k = 0; k < 255; k++) srgb_mid[k] = to_linear(2 * k + 1);
      errors = 0;
    endfunction

    function logic [7:0] encode_srgb(input logic [63:0] total);
      logic [63:0] s;
      int          m;
      s = total << 14;
      m = 0;
      for (int step = 128; step > 0; step >>= 1) begin
        if (m + step <= 255 && s >= 4 * srgb_mid[m + step - 1]) m = m + step;
      end
      return 8'(m);
    endfunction

    // True when 127.5 * a / sqrt(len2) + 128 reaches m.
    function bit normal_reaches(input longint a, input longint len2, input longint m);
      longint t;
      longint p;
      t = 2 * m - 256;
      p = 255 * a;
      if (p >= 0) return t <= 0 || p * p >= t * t * len2;
      return t < 0 && p * p <= t * t * len2;
    endfunction

    function logic [7:0] encode_normal(input longint a, input longint len2);
      longint m;
      m = 0;
      for (int step = 128; step > 0; step >>= 1) begin
        if (m + step <= 255 && normal_reaches(a, len2, m + step)) m = m + step;
      end
      return 8'(m);
    endfunction

    function texel_t predict(input quad_t q, input mode_e mode);
      logic [31:0] taps[4];
      logic [63:0] lin_sum[3];
      int          byte_sum[4];
      longint      a[3];
      longint      len2;
      logic [7:0]  res[4];
      texel_t      r;
      taps[0] = q.tap_top_left;
      taps[1] = q.tap_top_right;
      taps[2] = q.tap_bottom_left;
      taps[3] = q.tap_bottom_right;
      len2 = 0;
      for (int c = 0; c < 4; c++) begin
        byte_sum[c] = 0;
        if (c < 3) lin_sum[c] = 0;
        for (int t = 0; t < 4; t++) begin
          byte_sum[c] += taps[t][8 * c +: 8];
          if (c < 3) lin_sum[c] += srgb_lin[taps[t][8 * c +: 8]];
        end
        res[c] = 8'((byte_sum[c] + 2) >> 2);
      end
      if (mode == MODE_SRGB) begin
        for (int c = 0; c < 3; c++) res[c] = encode_srgb(lin_sum[c]);
      end else if (mode == MODE_NORMAL) begin
        for (int c = 0; c < 3; c++) begin
          a[c] = 2 * byte_sum[c] - 1020;
          len2 += a[c] * a[c];
        end
        for (int c = 0; c < 3; c++) begin
          res[c] = (len2 == 0) ? ((c == 2) ? 8'd255 : 8'd128) : encode_normal(a[c], len2);
        end
        res[3] = 8'd255;
      end
      r.out_red = res[0];
      r.out_green = res[1];
      r.out_blue = res[2];
      r.out_alpha = res[3];
      r.rejected = 1'b0;
      if (mode == MODE_HDR) r = '{rejected: 1'b1, default: '0};
      return r;
    endfunction

    function void note_quad(input quad_t q, input mode_e mode);
      pending = {pending, predict(q, mode)};
    endfunction

    function void check_texel(input texel_t got);
      texel_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected texel %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue || got.out_alpha !== want.out_alpha ||
          got.rejected !== want.rejected) begin
        errors++;
        if (errors <= 10) begin
          $display("texel mismatch: expected r%h g%h b%h a%h rej%b, got r%h g%h b%h a%h rej%b",
                   want.out_red, want.out_green, want.out_blue, want.out_alpha,
                   want.rejected, got.out_red, got.out_green, got.out_blue,
                   got.out_alpha, got.rejected);
        end
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  quad_t      in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  texel_t     out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i;

  texel_scoreboard board;
  mode_e           cur_mode;
  int              idle_pct;
  int              stall_pct;
  bit              hold_req;
  bit              hold_go;

  mip_quad_downsample dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // The run is ended here if the block hangs.
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // Both transfer directions are observed at the edge where they happen, so
  // expectations are noted in acceptance order and checked in arrival order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_quad(in_data_i, cur_mode);
      if (out_valid_o && !out_stall_i) board.check_texel(out_data_o);
    end
  end

  // The receiver stalls at random, or solidly for a long stretch when asked,
  // so that the pipeline fills and the block pushes back on its input.
  always @(posedge clk_i) begin
    out_stall_i <= hold_req || ($urandom_range(99) < stall_pct);
  end

  initial begin
    hold_req = 1'b0;
    wait (hold_go);
    hold_req = 1'b1;
    repeat (80) @(posedge clk_i);
    hold_req = 1'b0;
  end

  task automatic send_quad(input quad_t q);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= q;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // The mode is changed only with the pipeline drained and settled.
  task automatic set_mode(input mode_e mode);
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_mode = mode;
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] edges[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    return edges[$urandom_range(5)];
  endfunction

  // Independent random taps, flat quads, near-flat quads and quads built from
  // boundary bytes, in equal shares.
  function automatic quad_t random_quad();
    logic [31:0] base;
    logic [31:0] taps[4];
    int          kind;
    kind = $urandom_range(3);
    base = $urandom;
    for (int t = 0; t < 4; t++) begin
      case (kind)
        0: taps[t] = $urandom;
        1: taps[t] = base;
        2: taps[t] = base ^ ($urandom & 32'h0303_0303);
        default: taps[t] = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
      endcase
    end
    return '{taps[3], taps[2], taps[1], taps[0]};
  endfunction

  initial begin
    mode_e phase_mode[8];
    int    idle_set[4];
    int    stall_set[4];
    phase_mode = '{MODE_DATA, MODE_SRGB, MODE_NORMAL, MODE_HDR,
                   MODE_SRGB, MODE_NORMAL, MODE_DATA, MODE_SRGB};
    idle_set = '{0, 69, 0, 14};
    stall_set = '{0, 0, 69, 14};
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = MODE_DATA;
    cur_mode = MODE_DATA;
    idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed quads in every mode: black, white, alternating bit patterns,
    // the zero-length normal and a single bright tap.
    foreach (phase_mode[i]) begin
      if (i >= 4) break;
      set_mode(phase_mode[i]);
      send_quad('0);
      send_quad('1);
      send_quad({4{32'hAA55_AA55}});
      send_quad({32'h807F_807F, 32'h7F80_7F80, 32'h807F_807F, 32'h7F80_7F80});
      send_quad({96'd0, 32'hFF01_FF80});
      send_quad({32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, 32'hFF00_0000});
    end

    foreach (phase_mode[i]) begin
      set_mode(phase_mode[i]);
      idle_pct = idle_set[i % 4];
      stall_pct = stall_set[i % 4];
      if (i == 4) hold_go = 1'b1;
      repeat (63) send_quad(random_quad());
    end

    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
